// ===== rtl/bsoc_pkg.sv =====
package bsoc_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_DIV_Q,
        ST_SOC,
        ST_OCV,
        ST_DIV_O,
        ST_BLEND_A,
        ST_BLEND_B,
        ST_DONE
    } t_state;

    // op codes
    localparam logic [1:0] OP_UPDATE  = 2'd0;
    localparam logic [1:0] OP_SET     = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_ETA_CHG  = 3'd0;
    localparam logic [2:0] CFG_ETA_DIS  = 3'd1;
    localparam logic [2:0] CFG_CAPACITY = 3'd2;
    localparam logic [2:0] CFG_IDLE_THR = 3'd3;
    localparam logic [2:0] CFG_IDLE_TMO = 3'd4;
    localparam logic [2:0] CFG_OCV_W    = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // divider operand widths
    localparam int DIVD_W = 53;
    localparam int DIVS_W = 40;

    localparam logic [19:0] SOC_FULL = 20'd1000000;
    localparam logic [19:0] SOC_HIGH = 20'd950000;
    localparam logic [19:0] SOC_LOW  = 20'd150000;
    localparam logic [16:0] W_ONE    = 17'd65536;

    localparam int OCV_POINTS = 12;

    localparam logic [15:0] OCV_MV [OCV_POINTS] = '{
        16'd3000, 16'd3200, 16'd3400, 16'd3550, 16'd3650, 16'd3700,
        16'd3750, 16'd3800, 16'd3900, 16'd4000, 16'd4100, 16'd4200
    };
    localparam logic [19:0] OCV_SOC [OCV_POINTS] = '{
        20'd0, 20'd50000, 20'd100000, 20'd200000, 20'd350000, 20'd500000,
        20'd650000, 20'd750000, 20'd850000, 20'd920000, 20'd970000, 20'd1000000
    };

    // one interpolation segment of the ocv curve
    typedef struct packed {
        logic        direct;
        logic [19:0] base;
        logic [19:0] dsoc;
        logic [15:0] dmv;
        logic [15:0] span;
    } t_ocv_seg;

    function automatic t_ocv_seg ocv_segment(input logic [15:0] mv);
        t_ocv_seg s;
        logic     found;
        s     = '0;
        found = 1'b0;
        if (mv <= OCV_MV[0]) begin
            s.direct = 1'b1;
            s.base   = OCV_SOC[0];
        end else if (mv >= OCV_MV[OCV_POINTS-1]) begin
            s.direct = 1'b1;
            s.base   = OCV_SOC[OCV_POINTS-1];
        end else begin
            for (int i = 1; i < OCV_POINTS; i++) begin
                if (!found && mv <= OCV_MV[i]) begin
                    found  = 1'b1;
                    s.base = OCV_SOC[i-1];
                    s.dsoc = OCV_SOC[i] - OCV_SOC[i-1];
                    s.dmv  = mv - OCV_MV[i-1];
                    s.span = OCV_MV[i] - OCV_MV[i-1];
                end
            end
        end
        return s;
    endfunction

endpackage

// ===== rtl/bsoc_if.sv =====
interface bsoc_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic signed [15:0] charge_ma;
    logic signed [15:0] load_ma;
    logic [15:0]       battery_mv;
    logic [15:0]       step_ms;
    logic [31:0]       now_ms;
    logic [19:0]       new_soc;
    modport source (output valid, op, charge_ma, load_ma, battery_mv, step_ms, now_ms,
                    new_soc, input ready);
    modport sink (input valid, op, charge_ma, load_ma, battery_mv, step_ms, now_ms,
                  new_soc, output ready);
endinterface

interface bsoc_out_if;
    logic               valid;
    logic               ready;
    logic [19:0]        soc_out;
    logic signed [47:0] charge_total_uc;
    logic               is_idle;
    logic               ocv_applied;
    modport source (output valid, soc_out, charge_total_uc, is_idle, ocv_applied,
                    input ready);
    modport sink (input valid, soc_out, charge_total_uc, is_idle, ocv_applied,
                  output ready);
endinterface

interface bsoc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [39:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/battery_soc_coulomb_ocv_estimator_core.sv =====
// Battery state-of-charge gauge: coulomb counting with an open-circuit-voltage correction.
// Each input item carries an op: a measurement update weights the net current
// (charge_ma - load_ma) by the charge or discharge efficiency, integrates it over step_ms into
// a saturating 48-bit charge total, moves soc by dQ * 1e6 / capacity_uc and, after a long
// enough idle spell near either end of the range, blends soc with a 12-point ocv curve.
// Set and restart ops load soc directly. One result item is given per input item.
// Set, restart and the unused op go straight to the result; a measurement update runs the
// single 53-step restoring divider unless the capacity is zero, and when the ocv blend
// applies inside the curve the same divider runs a second time for the interpolation,
// but not when the voltage sits at or beyond either end of the curve. A stalled output
// delays the hand-over of the result and the return to ready. The block is not
// ready while an item is in work; a finished result waits in the output register while the
// next item is accepted. Configuration writes are always taken and must only be made while
// the block is idle.
module battery_soc_coulomb_ocv_estimator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsoc_in_if.sink     i_in,
    bsoc_out_if.source  o_out,
    bsoc_cfg_if.sink    i_cfg
);
    // configuration registers
    logic [15:0] r_eta_chg, r_eta_dis, r_idle_thr;
    logic [39:0] r_capacity;
    logic [31:0] r_idle_tmo;
    logic [16:0] r_ocv_w;

    // gauge state
    logic [19:0]        r_soc, n_soc;
    logic signed [47:0] r_acc, n_acc;
    logic [31:0]        r_since, n_since;
    logic               r_idle, n_idle;
    logic               r_applied, n_applied;

    // working registers
    bsoc_pkg::t_state r_state, n_state;
    logic        r_neg, n_neg;
    logic        r_pos, n_pos;
    logic [15:0] r_mag, n_mag;
    logic [15:0] r_step, n_step;
    logic [15:0] r_mv, n_mv;
    logic [31:0] r_now, n_now;
    logic [31:0] r_prod, n_prod;
    logic [32:0] r_dq, n_dq;
    logic [52:0] r_ds, n_ds;
    logic [19:0] r_so, n_so;
    logic [36:0] r_blend, n_blend;

    // output register
    logic               r_ovalid, n_ovalid;
    logic [19:0]        r_osoc, n_osoc;
    logic signed [47:0] r_oacc, n_oacc;
    logic               r_oidle, n_oidle;
    logic               r_oappl, n_oappl;

    // divider hookup
    logic        div_start;
    logic [52:0] div_dividend;
    logic [39:0] div_divisor;
    logic        div_done;
    logic [52:0] div_quot;

    bsoc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // helper terms
    logic signed [16:0] inet;
    logic [47:0]        prod48;
    logic signed [48:0] acc_sum;
    logic signed [48:0] dq_signed;
    logic [20:0]        room;
    logic [31:0]        elapsed;
    logic [16:0]        w_sat;
    bsoc_pkg::t_ocv_seg seg;
    logic [37:0]        blend_sum;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == bsoc_pkg::ST_IDLE);

    assign o_out.valid           = r_ovalid;
    assign o_out.soc_out         = r_osoc;
    assign o_out.charge_total_uc = r_oacc;
    assign o_out.is_idle         = r_oidle;
    assign o_out.ocv_applied     = r_oappl;

    always_comb begin
        inet      = 17'(i_in.charge_ma) - 17'(i_in.load_ma);
        prod48    = 48'(r_prod) * 48'(r_pos ? r_eta_chg : r_eta_dis);
        dq_signed = r_neg ? -$signed({16'b0, r_dq}) : $signed({16'b0, r_dq});
        acc_sum   = {r_acc[47], r_acc} + dq_signed;
        room      = 21'(bsoc_pkg::SOC_FULL) - 21'(r_soc);
        elapsed   = r_now - r_since;
        w_sat     = (r_ocv_w > bsoc_pkg::W_ONE) ? bsoc_pkg::W_ONE : r_ocv_w;
        seg       = bsoc_pkg::ocv_segment(r_mv);
        blend_sum = 38'(r_blend) + 38'(37'(w_sat) * 37'(r_so));
    end

    always_comb begin
        n_state   = r_state;
        n_soc     = r_soc;
        n_acc     = r_acc;
        n_since   = r_since;
        n_idle    = r_idle;
        n_applied = r_applied;
        n_neg     = r_neg;
        n_pos     = r_pos;
        n_mag     = r_mag;
        n_step    = r_step;
        n_mv      = r_mv;
        n_now     = r_now;
        n_prod    = r_prod;
        n_dq      = r_dq;
        n_ds      = r_ds;
        n_so      = r_so;
        n_blend   = r_blend;
        n_ovalid  = r_ovalid;
        n_osoc    = r_osoc;
        n_oacc    = r_oacc;
        n_oidle   = r_oidle;
        n_oappl   = r_oappl;
        div_start    = 1'b0;
        div_dividend = 53'(r_dq) * 53'd1000000;
        div_divisor  = r_capacity;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            bsoc_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_applied = 1'b0;
                    n_state   = bsoc_pkg::ST_DONE;
                    case (i_in.op) inside
                        bsoc_pkg::OP_UPDATE: begin
                            n_neg   = inet[16];
                            n_pos   = !inet[16] && (inet != 17'sd0);
                            n_mag   = inet[16] ? 16'(-inet) : inet[15:0];
                            n_step  = i_in.step_ms;
                            n_mv    = i_in.battery_mv;
                            n_now   = i_in.now_ms;
                            n_state = bsoc_pkg::ST_MUL_A;
                        end
                        bsoc_pkg::OP_SET, bsoc_pkg::OP_RESTART: begin
                            n_soc = (i_in.new_soc > bsoc_pkg::SOC_FULL) ?
                                    bsoc_pkg::SOC_FULL : i_in.new_soc;
                            if (i_in.op == bsoc_pkg::OP_RESTART) begin
                                n_acc   = '0;
                                n_since = '0;
                                n_idle  = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            bsoc_pkg::ST_MUL_A: begin
                // current magnitude times step
                n_prod  = 32'(r_mag) * 32'(r_step);
                n_state = bsoc_pkg::ST_MUL_B;
            end
            bsoc_pkg::ST_MUL_B: begin
                // efficiency weighting, q1.15
                n_dq    = prod48[47:15];
                n_state = bsoc_pkg::ST_MUL_C;
            end
            bsoc_pkg::ST_MUL_C: begin
                // saturating charge total
                if (acc_sum[48] != acc_sum[47]) begin
                    n_acc = acc_sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
                end else begin
                    n_acc = acc_sum[47:0];
                end
                if (r_capacity == 40'd0) begin
                    n_ds    = '0;
                    n_state = bsoc_pkg::ST_SOC;
                end else begin
                    div_start = 1'b1;
                    n_state   = bsoc_pkg::ST_DIV_Q;
                end
            end
            bsoc_pkg::ST_DIV_Q: begin
                if (div_done) begin
                    n_ds    = div_quot;
                    n_state = bsoc_pkg::ST_SOC;
                end
            end
            bsoc_pkg::ST_SOC: begin
                // clamped soc update, then idle tracking
                if (r_neg) begin
                    n_soc = (r_ds >= 53'(r_soc)) ? 20'd0 : 20'(53'(r_soc) - r_ds);
                end else begin
                    n_soc = (r_ds >= 53'(room)) ? bsoc_pkg::SOC_FULL :
                            20'(53'(r_soc) + r_ds);
                end
                n_state = bsoc_pkg::ST_DONE;
                if (r_mag < r_idle_thr) begin
                    if (!r_idle) begin
                        n_since = r_now;
                        n_idle  = 1'b1;
                    end else if (elapsed > r_idle_tmo &&
                                 (n_soc > bsoc_pkg::SOC_HIGH || n_soc < bsoc_pkg::SOC_LOW)) begin
                        n_state = bsoc_pkg::ST_OCV;
                    end
                end else begin
                    n_idle = 1'b0;
                end
            end
            bsoc_pkg::ST_OCV: begin
                if (seg.direct) begin
                    n_so    = seg.base;
                    n_state = bsoc_pkg::ST_BLEND_A;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = 53'(36'(seg.dsoc) * 36'(seg.dmv));
                    div_divisor  = 40'(seg.span);
                    n_so         = seg.base;
                    n_state      = bsoc_pkg::ST_DIV_O;
                end
            end
            bsoc_pkg::ST_DIV_O: begin
                if (div_done) begin
                    n_so    = r_so + div_quot[19:0];
                    n_state = bsoc_pkg::ST_BLEND_A;
                end
            end
            bsoc_pkg::ST_BLEND_A: begin
                n_blend = 37'(bsoc_pkg::W_ONE - w_sat) * 37'(r_soc);
                n_state = bsoc_pkg::ST_BLEND_B;
            end
            bsoc_pkg::ST_BLEND_B: begin
                n_soc     = blend_sum[35:16];
                n_applied = 1'b1;
                n_state   = bsoc_pkg::ST_DONE;
            end
            bsoc_pkg::ST_DONE: begin
                // hand over once the output register is free
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_osoc   = r_soc;
                    n_oacc   = r_acc;
                    n_oidle  = r_idle;
                    n_oappl  = r_applied;
                    n_state  = bsoc_pkg::ST_IDLE;
                end
            end
            default: n_state = bsoc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bsoc_pkg::ST_IDLE;
            r_soc     <= '0;
            r_acc     <= '0;
            r_since   <= '0;
            r_idle    <= 1'b0;
            r_applied <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_soc     <= n_soc;
            r_acc     <= n_acc;
            r_since   <= n_since;
            r_idle    <= n_idle;
            r_applied <= n_applied;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_pos   <= n_pos;
        r_mag   <= n_mag;
        r_step  <= n_step;
        r_mv    <= n_mv;
        r_now   <= n_now;
        r_prod  <= n_prod;
        r_dq    <= n_dq;
        r_ds    <= n_ds;
        r_so    <= n_so;
        r_blend <= n_blend;
        r_osoc  <= n_osoc;
        r_oacc  <= n_oacc;
        r_oidle <= n_oidle;
        r_oappl <= n_oappl;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_chg  <= 16'd32768;
            r_eta_dis  <= 16'd32768;
            r_capacity <= 40'd9000000000;
            r_idle_thr <= 16'd50;
            r_idle_tmo <= 32'd1800000;
            r_ocv_w    <= 17'd6554;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bsoc_pkg::CFG_ETA_CHG:  r_eta_chg  <= i_cfg.data[15:0];
                bsoc_pkg::CFG_ETA_DIS:  r_eta_dis  <= i_cfg.data[15:0];
                bsoc_pkg::CFG_CAPACITY: r_capacity <= i_cfg.data[39:0];
                bsoc_pkg::CFG_IDLE_THR: r_idle_thr <= i_cfg.data[15:0];
                bsoc_pkg::CFG_IDLE_TMO: r_idle_tmo <= i_cfg.data[31:0];
                bsoc_pkg::CFG_OCV_W:    r_ocv_w    <= i_cfg.data[16:0];
                default: ;
            endcase
        end
    end
endmodule

// ===== rtl/bsoc_div.sv =====
module bsoc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [bsoc_pkg::DIVD_W-1:0]    i_dividend,
    input  logic [bsoc_pkg::DIVS_W-1:0]    i_divisor,
    output logic                           o_done,
    output logic [bsoc_pkg::DIVD_W-1:0]    o_quot
);
    // restoring divider, one quotient bit a cycle
    logic [bsoc_pkg::DIVS_W-1:0] r_rem, n_rem;
    logic [bsoc_pkg::DIVS_W-1:0] r_dvs;
    logic [bsoc_pkg::DIVD_W-1:0] r_quo, n_quo;
    logic [5:0]                  r_cnt;
    logic                        r_busy, r_done;
    logic [bsoc_pkg::DIVS_W:0]   trial;

    always_comb begin
        trial = {r_rem, r_quo[bsoc_pkg::DIVD_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = bsoc_pkg::DIVS_W'(trial - {1'b0, r_dvs});
            n_quo = {r_quo[bsoc_pkg::DIVD_W-2:0], 1'b1};
        end else begin
            n_rem = trial[bsoc_pkg::DIVS_W-1:0];
            n_quo = {r_quo[bsoc_pkg::DIVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(bsoc_pkg::DIVD_W - 1);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// ===== sim/tb_if.sv =====
`timescale 1ns / 100ps

// interfaces come from the rtl; this file only holds the scoreboard item types
package tb_types_pkg;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] charge_ma;
        logic signed [15:0] load_ma;
        logic [15:0]        battery_mv;
        logic [15:0]        step_ms;
        logic [31:0]        now_ms;
        logic [19:0]        new_soc;
    } t_meas;

    typedef struct packed {
        logic [19:0]        soc;
        logic signed [47:0] charge;
        logic               idle;
        logic               ocv;
    } t_gauge;

endpackage

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import bsoc_pkg::*;
    import tb_types_pkg::*;

    logic i_clk;
    logic i_rst_n;

    bsoc_in_if  in_if ();
    bsoc_out_if out_if ();
    bsoc_cfg_if cfg_if ();

    battery_soc_coulomb_ocv_estimator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // gauge predictor and queue of expected soc reports
    class gauge_scoreboard;
        logic [15:0] eta_chg, eta_dis, idle_thr;
        logic [39:0] capacity;
        logic [31:0] idle_tmo;
        logic [16:0] ocv_w;
        logic [19:0] soc;
        logic signed [47:0] acc;
        logic [31:0] idle_since;
        logic        idle;
        t_gauge      pending[$];
        int          errors;
        int          checked;
        int          ocv_seen;

        function new();
            eta_chg = 16'd32768; eta_dis = 16'd32768;
            capacity = 40'd9000000000; idle_thr = 16'd50;
            idle_tmo = 32'd1800000; ocv_w = 17'd6554;
            soc = '0; acc = '0; idle_since = '0; idle = 1'b0;
            errors = 0; checked = 0; ocv_seen = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [39:0] d);
            case (idx)
                CFG_ETA_CHG:  eta_chg  = d[15:0];
                CFG_ETA_DIS:  eta_dis  = d[15:0];
                CFG_CAPACITY: capacity = d;
                CFG_IDLE_THR: idle_thr = d[15:0];
                CFG_IDLE_TMO: idle_tmo = d[31:0];
                CFG_OCV_W:    ocv_w    = d[16:0];
                default: ;
            endcase
        endfunction

        function logic [19:0] curve_soc(logic [15:0] mv);
            logic [63:0] part;
            if (mv <= OCV_MV[0]) return OCV_SOC[0];
            if (mv >= OCV_MV[OCV_POINTS-1]) return OCV_SOC[OCV_POINTS-1];
            for (int i = 1; i < OCV_POINTS; i++) begin
                if (mv <= OCV_MV[i]) begin
                    part = 64'(OCV_SOC[i] - OCV_SOC[i-1]) * 64'(mv - OCV_MV[i-1])
                           / 64'(OCV_MV[i] - OCV_MV[i-1]);
                    return OCV_SOC[i-1] + part[19:0];
                end
            end
            return OCV_SOC[OCV_POINTS-1];
        endfunction

        function void note_input(t_meas m);
            t_gauge r;
            longint inet, mag, dq_mag, nacc, ns, ds;
            logic [63:0] eta, w, blend;
            logic [19:0] s;
            r.ocv = 1'b0;
            if (m.op == OP_SET || m.op == OP_RESTART) begin
                s = m.new_soc;
                soc = (s > SOC_FULL) ? SOC_FULL : s;
                if (m.op == OP_RESTART) begin
                    acc = '0; idle_since = '0; idle = 1'b0;
                end
            end else if (m.op == OP_UPDATE) begin
                inet = longint'(m.charge_ma) - longint'(m.load_ma);
                mag = (inet < 0) ? -inet : inet;
                eta = (inet > 0) ? eta_chg : eta_dis;
                dq_mag = (mag * longint'(m.step_ms) * longint'(eta)) >>> 15;
                nacc = longint'(acc) + ((inet < 0) ? -dq_mag : dq_mag);
                if (nacc > 64'sd140737488355327) nacc = 64'sd140737488355327;
                if (nacc < -64'sd140737488355328) nacc = -64'sd140737488355328;
                acc = nacc[47:0];
                ns = longint'(soc);
                if (capacity != 0) begin
                    ds = longint'((64'(dq_mag) * 64'd1000000) / 64'(capacity));
                    ns += (inet < 0) ? -ds : ds;
                end
                if (ns < 0) ns = 0;
                if (ns > 1000000) ns = 1000000;
                soc = ns[19:0];
                if (mag < longint'(idle_thr)) begin
                    if (!idle) begin
                        idle_since = m.now_ms; idle = 1'b1;
                    end else if (32'(m.now_ms - idle_since) > idle_tmo) begin
                        if (soc > SOC_HIGH || soc < SOC_LOW) begin
                            w = (ocv_w > W_ONE) ? 64'(W_ONE) : 64'(ocv_w);
                            blend = ((64'd65536 - w) * 64'(soc)
                                     + w * 64'(curve_soc(m.battery_mv))) >> 16;
                            soc = blend[19:0];
                            r.ocv = 1'b1;
                        end
                    end
                end else begin
                    idle = 1'b0;
                end
            end
            r.soc = soc; r.charge = acc; r.idle = idle;
            pending.push_back(r);
        endfunction

        function void check_result(t_gauge got);
            t_gauge want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result soc %0d", $time, got.soc);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.ocv) ocv_seen++;
            if (got.soc !== want.soc) begin
                $display("%0t: soc expected %0d actual %0d", $time, want.soc, got.soc);
                errors++;
            end
            if (got.charge !== want.charge) begin
                $display("%0t: charge expected %0d actual %0d", $time, want.charge,
                         got.charge);
                errors++;
            end
            if (got.idle !== want.idle) begin
                $display("%0t: idle expected %b actual %b", $time, want.idle, got.idle);
                errors++;
            end
            if (got.ocv !== want.ocv) begin
                $display("%0t: ocv flag expected %b actual %b", $time, want.ocv, got.ocv);
                errors++;
            end
        endfunction
    endclass

    gauge_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    logic [31:0] clock_ms;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // overall watchdog, far beyond the slowest legal run
    initial begin
        #20ms;
        $display("tb_top failed");
        $finish;
    end

    // result side: random stall, check every accepted item
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready)
                sb.check_result('{out_if.soc_out, out_if.charge_total_uc,
                                  out_if.is_idle, out_if.ocv_applied});
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_meas(t_meas m);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        in_if.valid      <= 1'b1;
        in_if.op         <= m.op;
        in_if.charge_ma  <= m.charge_ma;
        in_if.load_ma    <= m.load_ma;
        in_if.battery_mv <= m.battery_mv;
        in_if.step_ms    <= m.step_ms;
        in_if.now_ms     <= m.now_ms;
        in_if.new_soc    <= m.new_soc;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_input(m);
        in_if.valid <= 1'b0;
        // the block is busy for at least this cycle after an accepted item
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [39:0] d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(idx, d);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every result, then let the clock run on before the next phase
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic t_meas upd(int chg, int ld, int mv, int st, logic [31:0] now);
        t_meas m;
        m.op = OP_UPDATE; m.charge_ma = chg[15:0]; m.load_ma = ld[15:0];
        m.battery_mv = mv[15:0]; m.step_ms = st[15:0]; m.now_ms = now; m.new_soc = '0;
        return m;
    endfunction

    function automatic t_meas load_soc(logic [1:0] op, logic [19:0] s);
        t_meas m;
        m = '0; m.op = op; m.new_soc = s;
        m.charge_ma = 16'($urandom); m.load_ma = 16'($urandom);
        return m;
    endfunction

    // random item of every op; many are idle spells near the ends so the ocv blend fires
    function automatic t_meas rand_item();
        t_meas m;
        int pick;
        pick = $urandom_range(99);
        clock_ms = clock_ms + $urandom_range(3000000);
        if (pick < 8) begin
            m = load_soc(OP_RESTART, 20'($urandom_range(1) ? $urandom_range(140000)
                                          : 960000 + $urandom_range(88575)));
        end else if (pick < 14) begin
            m = load_soc(OP_SET, 20'($urandom));
        end else if (pick < 17) begin
            m = t_meas'($bits(t_meas)'({$urandom, $urandom, $urandom, $urandom}));
            m.op = 2'd3;
        end else if (pick < 60) begin
            m = upd($urandom_range(60) - 30, $urandom_range(60) - 30,
                    2800 + $urandom_range(1600), $urandom_range(2000), clock_ms);
        end else if (pick < 70) begin
            m = upd(32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                    $urandom);
        end else begin
            m = upd($urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
                    $urandom_range(65535), $urandom_range(65535), clock_ms);
        end
        return m;
    endfunction

    initial begin
        sb = new();
        send_idle_pct = 0; recv_idle_pct = 0; clock_ms = '0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0; in_if.op = OP_UPDATE; in_if.charge_ma = '0;
        in_if.load_ma = '0; in_if.battery_mv = '0; in_if.step_ms = '0;
        in_if.now_ms = '0; in_if.new_soc = '0;
        cfg_if.valid = 1'b0; cfg_if.index = CFG_ETA_CHG; cfg_if.data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, every op, clamps, saturation, idle and wrap
        write_reg(CFG_IDLE_TMO, 40'd1000);
        send_meas(load_soc(OP_SET, 20'hFFFFF));
        send_meas(load_soc(OP_RESTART, 20'd1000001));
        send_meas(upd(32767, -32768, 65535, 65535, 32'd0));
        send_meas(upd(-32768, 32767, 0, 65535, 32'd1));
        send_meas(load_soc(2'd3, 20'd5));
        send_meas(load_soc(OP_RESTART, 20'd990000));
        send_meas(upd(10, 10, 4300, 100, 32'hFFFFFF00));
        send_meas(upd(0, 20, 4300, 100, 32'd2000));
        send_meas(upd(0, 0, 3000, 0, 32'd4000));
        send_meas(load_soc(OP_SET, 20'd10000));
        send_meas(upd(5, 0, 3625, 1, 32'd9000));
        send_meas(upd(0, 49, 2000, 1, 32'd20000));
        send_meas(upd(0, 50, 4000, 1000, 32'd30000));
        drain();
        // extremes: zero and full scale efficiencies, zero and tiny capacity, full weight
        write_reg(CFG_ETA_CHG, 40'd0);
        write_reg(CFG_ETA_DIS, 40'hFFFF);
        write_reg(CFG_CAPACITY, 40'd0);
        write_reg(CFG_IDLE_THR, 40'hFFFF);
        write_reg(CFG_IDLE_TMO, 40'd0);
        write_reg(CFG_OCV_W, 40'h1FFFF);
        send_meas(load_soc(OP_RESTART, 20'd100));
        send_meas(upd(100, 0, 3555, 10, 32'd5));
        send_meas(upd(0, 100, 3555, 10, 32'd6));
        send_meas(upd(0, 100, 4150, 10, 32'd7));
        drain();
        write_reg(CFG_CAPACITY, 40'd1);
        write_reg(CFG_OCV_W, 40'd65536);
        for (int i = 0; i < 4; i++) send_meas(upd(-32768, 32767, 3100, 65535, 32'(i)));
        drain();

        // random phases with differing settings and idling
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 72 : 0;
            recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 12 : 0;
            write_reg(CFG_ETA_CHG, 40'($urandom_range(32768)));
            write_reg(CFG_ETA_DIS, 40'($urandom_range(32768)));
            write_reg(CFG_CAPACITY, (ph == 2) ? 40'hFFFFFFFFFF
                                              : 40'(1 + $urandom_range(200000000)));
            write_reg(CFG_IDLE_THR, 40'($urandom_range(80)));
            write_reg(CFG_IDLE_TMO, 40'($urandom_range(2000000)));
            write_reg(CFG_OCV_W, 40'($urandom_range(65536)));
            for (int k = 0; k < 160; k++) begin
                send_meas(rand_item());
                // halfway through, the sender holds off until all results are back
                if (k == 80) while (sb.pending.size() != 0) @(posedge i_clk);
            end
            drain();
        end

        $display("run checked %0d results, %0d with the ocv blend, over three settings",
                 sb.checked, sb.ocv_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
